[rtl/bbl_pkg.sv]
// Shared types and constants for the byte-budget LRU cache directory.
// No dependencies.
package bbl_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam logic [39:0] CAPACITY_RESET = 40'd1073741824;

   localparam logic [2:0] ACT_LOOKUP   = 3'd0;
   localparam logic [2:0] ACT_PROBE    = 3'd1;
   localparam logic [2:0] ACT_PREFETCH = 3'd2;
   localparam logic [2:0] ACT_EVICT    = 3'd3;
   localparam logic [2:0] ACT_CLEAR    = 3'd4;

   typedef struct packed {
      logic        valid;
      logic [15:0] model;
      logic [15:0] tensor;
      logic [33:0] bytes;
      logic [31:0] stamp;
   } slot_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DECIDE = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

endpackage

[rtl/bbl_cell.sv]
// One slot of the rotating directory ring.
// Depends on bbl_pkg.
module bbl_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              clear_all,
   input  bbl_pkg::slot_type slot_d,
   output bbl_pkg::slot_type slot_q
);

   logic              valid_ff;
   bbl_pkg::slot_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (clear_all) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= slot_d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= slot_d;
      end
   end

   always_comb begin
      slot_q       = data_ff;
      slot_q.valid = valid_ff;
   end

endmodule

[rtl/byte_budget_lru_cache_directory_core.sv]
// Byte-budget LRU cache directory: top level with ring of slot cells and sequencer.
// Depends on bbl_pkg and bbl_cell.
// Each request rotates the slot ring once per pass, one slot per cycle.
// Lookup, probe, evict-model and a prefetch that hits or is refused make one scan pass.
// Clear and unknown actions skip the scan; a loading prefetch rescans per eviction and insertion.
// Synchronous reset empties all slots, zeroes counters and sets the budget to 2^30.
module byte_budget_lru_cache_directory_core #(
   parameter int ENTRIES = bbl_pkg::ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_model_id,
   input  logic [15:0] req_tensor_id,
   input  logic [31:0] req_element_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic        rsp_ok,
   output logic [5:0]  rsp_slot,
   output logic [6:0]  rsp_evicted_count,
   output logic [39:0] rsp_used_bytes,
   output logic [6:0]  rsp_entry_count,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_miss_total,
   output logic [31:0] rsp_eviction_total,
   output logic [31:0] rsp_load_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [39:0] csr_data
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   bbl_pkg::slot_type ring_q [ENTRIES];
   bbl_pkg::slot_type ring_d [ENTRIES];
   bbl_pkg::slot_type head;

   bbl_pkg::state_type state_ff, state_in;
   logic [IW-1:0] h_ff, h_in;
   logic [2:0]    act_ff, act_in;
   logic [15:0]   model_ff, model_in, tensor_ff, tensor_in;
   logic [33:0]   size_ff, size_in;
   logic [39:0]   cap_ff, cap_in, used_ff, used_in;
   logic [CW-1:0] vcnt_ff, vcnt_in, evd_ff, evd_in;
   logic [31:0]   clk_ff, clk_in, hitc_ff, hitc_in, missc_ff, missc_in;
   logic [31:0]   evc_ff, evc_in, loadc_ff, loadc_in;
   logic          first_ff, first_in;
   logic          found_ff, found_in, best_v_ff, best_v_in, free_f_ff, free_f_in;
   logic [IW-1:0] found_idx_ff, found_idx_in, best_idx_ff, best_idx_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [31:0]   best_age_ff, best_age_in;
   logic          fpend_ff, fpend_in, ipend_ff, ipend_in;
   logic [IW-1:0] ftgt_ff, ftgt_in, itgt_ff, itgt_in;
   logic          hit_ff, hit_in, ok_ff, ok_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic          rv_ff, rv_in;
   logic          r_hit_ff, r_hit_in, r_ok_ff, r_ok_in;
   logic [5:0]    r_slot_ff, r_slot_in;
   logic [6:0]    r_evd_ff, r_evd_in, r_ent_ff, r_ent_in;
   logic [39:0]   r_used_ff, r_used_in;
   logic [31:0]   r_hit_t_ff, r_hit_t_in, r_miss_t_ff, r_miss_t_in;
   logic [31:0]   r_ev_t_ff, r_ev_t_in, r_load_t_ff, r_load_t_in;

   logic          shift, clear_all, match, last, need;
   logic [31:0]   age;
   logic [40:0]   sum;
   logic [IW+5:0] slot_ext;
   logic [CW+6:0] evd_ext, ent_ext;

   assign head = ring_q[0];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_ring
      bbl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .clear_all (clear_all),
         .slot_d    (ring_d[i]),
         .slot_q    (ring_q[i])
      );
   end

   assign slot_ext = {6'd0, slot_ff};
   assign evd_ext  = {7'd0, evd_ff};
   assign ent_ext  = {7'd0, vcnt_ff};
   assign last     = (h_ff == IW'(ENTRIES - 1));
   assign sum      = {1'b0, used_ff} + {7'd0, size_ff};
   assign need     = (vcnt_ff != '0) &&
                     ((sum > {1'b0, cap_ff}) || (vcnt_ff >= CW'(ENTRIES)));

   always_comb begin
      state_in = state_ff; h_in = h_ff; act_in = act_ff;
      model_in = model_ff; tensor_in = tensor_ff; size_in = size_ff;
      cap_in = cap_ff; used_in = used_ff; vcnt_in = vcnt_ff; evd_in = evd_ff;
      clk_in = clk_ff; hitc_in = hitc_ff; missc_in = missc_ff;
      evc_in = evc_ff; loadc_in = loadc_ff; first_in = first_ff;
      found_in = found_ff; found_idx_in = found_idx_ff;
      best_v_in = best_v_ff; best_idx_in = best_idx_ff; best_age_in = best_age_ff;
      free_f_in = free_f_ff; free_idx_in = free_idx_ff;
      fpend_in = fpend_ff; ftgt_in = ftgt_ff; ipend_in = ipend_ff; itgt_in = itgt_ff;
      hit_in = hit_ff; ok_in = ok_ff; slot_in = slot_ff;
      rv_in = rv_ff; r_hit_in = r_hit_ff; r_ok_in = r_ok_ff; r_slot_in = r_slot_ff;
      r_evd_in = r_evd_ff; r_ent_in = r_ent_ff; r_used_in = r_used_ff;
      r_hit_t_in = r_hit_t_ff; r_miss_t_in = r_miss_t_ff;
      r_ev_t_in = r_ev_t_ff; r_load_t_in = r_load_t_ff;
      shift = 1'b0; clear_all = 1'b0;
      match = 1'b0; age = '0;
      for (int i = 0; i < ENTRIES - 1; i++) begin
         ring_d[i] = ring_q[i + 1];
      end
      ring_d[ENTRIES - 1] = head;

      if (csr_valid) begin
         cap_in = csr_data;
      end
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         bbl_pkg::S_IDLE: begin
            if (req_valid) begin
               act_in = req_action; model_in = req_model_id;
               tensor_in = req_tensor_id; size_in = {req_element_count, 2'b00};
               hit_in = 1'b0; ok_in = 1'b0; slot_in = '0; evd_in = '0;
               first_in = 1'b1; fpend_in = 1'b0; ipend_in = 1'b0;
               h_in = '0; found_in = 1'b0; best_v_in = 1'b0; free_f_in = 1'b0;
               if (req_action == bbl_pkg::ACT_CLEAR) begin
                  clear_all = 1'b1; evd_in = vcnt_ff;
                  used_in = '0; vcnt_in = '0;
                  state_in = bbl_pkg::S_DONE;
               end else if (req_action > bbl_pkg::ACT_CLEAR) begin
                  state_in = bbl_pkg::S_DONE;
               end else begin
                  state_in = bbl_pkg::S_SCAN;
               end
            end
         end
         bbl_pkg::S_SCAN: begin
            shift = 1'b1;
            ring_d[ENTRIES - 1] = head;
            match = head.valid && head.model == model_ff && head.tensor == tensor_ff;
            if (fpend_ff && h_ff == ftgt_ff && head.valid) begin
               ring_d[ENTRIES - 1].valid = 1'b0;
               used_in = used_ff - {6'd0, head.bytes};
               vcnt_in = vcnt_ff - 1'b1; evd_in = evd_ff + 1'b1; evc_in = evc_ff + 1;
            end
            if (act_ff == bbl_pkg::ACT_EVICT && head.valid && head.model == model_ff) begin
               ring_d[ENTRIES - 1].valid = 1'b0;
               used_in = used_ff - {6'd0, head.bytes};
               vcnt_in = vcnt_ff - 1'b1; evd_in = evd_ff + 1'b1;
            end
            if (ipend_ff && h_ff == itgt_ff) begin
               ring_d[ENTRIES - 1] = '{1'b1, model_ff, tensor_ff, size_ff, clk_ff};
               clk_in = clk_ff + 1; used_in = sum[39:0];
               vcnt_in = vcnt_ff + 1'b1; loadc_in = loadc_ff + 1;
            end
            if (match && !found_ff) begin
               found_in = 1'b1; found_idx_in = h_ff;
               if (act_ff == bbl_pkg::ACT_LOOKUP) begin
                  ring_d[ENTRIES - 1].stamp = clk_ff;
                  clk_in = clk_ff + 1; hitc_in = hitc_ff + 1;
               end
            end
            age = clk_ff - ring_d[ENTRIES - 1].stamp;
            if (ring_d[ENTRIES - 1].valid) begin
               if (!best_v_ff || age > best_age_ff) begin
                  best_v_in = 1'b1; best_idx_in = h_ff; best_age_in = age;
               end
            end else if (!free_f_ff) begin
               free_f_in = 1'b1; free_idx_in = h_ff;
            end
            if (last) begin
               h_in = '0; state_in = bbl_pkg::S_DECIDE;
            end else begin
               h_in = h_ff + 1'b1;
            end
         end
         bbl_pkg::S_DECIDE: begin
            state_in = bbl_pkg::S_DONE;
            found_in = 1'b0; best_v_in = 1'b0; free_f_in = 1'b0;
            if (ipend_ff) begin
               ipend_in = 1'b0; ok_in = 1'b1; slot_in = itgt_ff;
            end else if (act_ff != bbl_pkg::ACT_PREFETCH) begin
               if (act_ff != bbl_pkg::ACT_EVICT) begin
                  hit_in = found_ff; slot_in = found_ff ? found_idx_ff : '0;
               end
               if (act_ff == bbl_pkg::ACT_LOOKUP && !found_ff) begin
                  missc_in = missc_ff + 1;
               end
            end else if (first_ff && found_ff) begin
               hit_in = 1'b1; ok_in = 1'b1; slot_in = found_idx_ff;
            end else if (first_ff && {6'd0, size_ff} > cap_ff) begin
               first_in = 1'b0;
            end else begin
               first_in = 1'b0; fpend_in = 1'b0;
               state_in = bbl_pkg::S_SCAN;
               if (need) begin
                  fpend_in = 1'b1; ftgt_in = best_idx_ff;
               end else begin
                  ipend_in = 1'b1; itgt_in = free_idx_ff;
               end
            end
         end
         bbl_pkg::S_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1; r_hit_in = hit_ff; r_ok_in = ok_ff;
               r_slot_in = slot_ext[5:0]; r_evd_in = evd_ext[6:0];
               r_used_in = used_ff; r_ent_in = ent_ext[6:0];
               r_hit_t_in = hitc_ff; r_miss_t_in = missc_ff;
               r_ev_t_in = evc_ff; r_load_t_in = loadc_ff;
               state_in = bbl_pkg::S_IDLE;
            end
         end
         default: state_in = bbl_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbl_pkg::S_IDLE;
         cap_ff <= bbl_pkg::CAPACITY_RESET;
         used_ff <= '0; vcnt_ff <= '0; clk_ff <= '0;
         hitc_ff <= '0; missc_ff <= '0; evc_ff <= '0; loadc_ff <= '0;
         fpend_ff <= 1'b0; ipend_ff <= 1'b0; rv_ff <= 1'b0;
         found_ff <= 1'b0; best_v_ff <= 1'b0; free_f_ff <= 1'b0;
         h_ff <= '0; first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff <= cap_in;
         used_ff <= used_in; vcnt_ff <= vcnt_in; clk_ff <= clk_in;
         hitc_ff <= hitc_in; missc_ff <= missc_in; evc_ff <= evc_in; loadc_ff <= loadc_in;
         fpend_ff <= fpend_in; ipend_ff <= ipend_in; rv_ff <= rv_in;
         found_ff <= found_in; best_v_ff <= best_v_in; free_f_ff <= free_f_in;
         h_ff <= h_in; first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; model_ff <= model_in; tensor_ff <= tensor_in; size_ff <= size_in;
      evd_ff <= evd_in; found_idx_ff <= found_idx_in; best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in; free_idx_ff <= free_idx_in;
      ftgt_ff <= ftgt_in; itgt_ff <= itgt_in;
      hit_ff <= hit_in; ok_ff <= ok_in; slot_ff <= slot_in;
      r_hit_ff <= r_hit_in; r_ok_ff <= r_ok_in; r_slot_ff <= r_slot_in;
      r_evd_ff <= r_evd_in; r_ent_ff <= r_ent_in; r_used_ff <= r_used_in;
      r_hit_t_ff <= r_hit_t_in; r_miss_t_ff <= r_miss_t_in;
      r_ev_t_ff <= r_ev_t_in; r_load_t_ff <= r_load_t_in;
   end

   assign req_stall          = (state_ff != bbl_pkg::S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rv_ff;
   assign rsp_hit            = r_hit_ff;
   assign rsp_ok             = r_ok_ff;
   assign rsp_slot           = r_slot_ff;
   assign rsp_evicted_count  = r_evd_ff;
   assign rsp_used_bytes     = r_used_ff;
   assign rsp_entry_count    = r_ent_ff;
   assign rsp_hit_total      = r_hit_t_ff;
   assign rsp_miss_total     = r_miss_t_ff;
   assign rsp_eviction_total = r_ev_t_ff;
   assign rsp_load_total     = r_load_t_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= CW'(ENTRIES))
      else $error("valid slot count above table size");

   a_pend_excl: assert property (@(posedge clock) disable iff (reset)
      !(fpend_ff && ipend_ff))
      else $error("eviction and insertion pending together");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff == bbl_pkg::S_DONE))
      else $error("response raised outside completion");

endmodule
